@@ hw/rtl/usbcdc_pkg.sv @@
// usbcdc_pkg: shared types, codes, descriptor rom and helpers for the ep0 responder
// no dependencies; compiled first
`default_nettype none

package usbcdc_pkg;

    localparam int MAX_PACKET   = 64;
    localparam int STRING_COUNT = 4;
    localparam int STRING_LIMIT = (STRING_COUNT < 4) ? STRING_COUNT : 4;

    localparam logic [1:0] KIND_BUS_RESET = 2'd0;
    localparam logic [1:0] KIND_SETUP     = 2'd1;
    localparam logic [1:0] KIND_IN_DONE   = 2'd2;

    localparam logic [1:0] GROUP_STANDARD = 2'd0;
    localparam logic [1:0] GROUP_CLASS    = 2'd1;

    localparam logic [7:0] REQ_SET_ADDRESS            = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR         = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIGURATION      = 8'h09;
    localparam logic [7:0] REQ_SET_LINE_CODING        = 8'h20;
    localparam logic [7:0] REQ_GET_LINE_CODING        = 8'h21;
    localparam logic [7:0] REQ_SET_CONTROL_LINE_STATE = 8'h22;

    localparam logic [7:0] DESC_DEVICE    = 8'h01;
    localparam logic [7:0] DESC_CONFIG    = 8'h02;
    localparam logic [7:0] DESC_STRING    = 8'h03;
    localparam logic [7:0] DESC_QUALIFIER = 8'h06;

    localparam logic [2:0] SRC_DEVICE      = 3'd0;
    localparam logic [2:0] SRC_CONFIG      = 3'd1;
    localparam logic [2:0] SRC_QUALIFIER   = 3'd2;
    localparam logic [2:0] SRC_LINE_CODING = 3'd3;
    localparam logic [2:0] SRC_STRING0     = 3'd4;

    typedef enum logic [2:0] {
        ACT_DATA    = 3'd0,
        ACT_ZLP     = 3'd1,
        ACT_ACK     = 3'd2,
        ACT_STALL   = 3'd3,
        ACT_ADDRESS = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SINGLE,
        ST_STREAM
    } t_state;

    typedef enum logic [1:0] {
        NEXT_NONE,
        NEXT_SINGLE,
        NEXT_CHUNK
    } t_next;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_req;

    typedef struct packed {
        t_action     action;
        logic [7:0]  data_byte;
        logic        packet_end;
        logic        final_packet;
        logic [6:0]  device_address;
        logic        configured;
        logic        dtr_on;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic accept;
        logic chunk_setup;
        logic emit_single;
        logic emit_byte;
    } t_ctrl_cmd;

    typedef struct packed {
        t_next next_step;
        logic  chunk_empty;
        logic  chunk_last;
        logic  out_free;
    } t_dp_status;

    localparam int ROM_DEPTH = 152;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam logic [7:0] MP_BYTE = 8'(MAX_PACKET);

    // device, configuration, qualifier, line coding, strings 0..3
    localparam logic [7:0] DESC_ROM [ROM_DEPTH] = '{
        8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h00, MP_BYTE,
        8'h1C, 8'h1C, 8'h10, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01,
        8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'hC0, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
        8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
        8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
        8'h04, 8'h24, 8'h02, 8'h02,
        8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
        8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hFF,
        8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h0A, 8'h06, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, MP_BYTE, 8'h01, 8'h00,
        8'h00, 8'hC2, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08,
        8'h04, 8'h03, 8'h09, 8'h04,
        8'h14, 8'h03, 8'h46, 8'h00, 8'h72, 8'h00, 8'h65, 8'h00, 8'h65, 8'h00,
        8'h74, 8'h00, 8'h72, 8'h00, 8'h69, 8'h00, 8'h62, 8'h00, 8'h65, 8'h00,
        8'h10, 8'h03, 8'h43, 8'h00, 8'h44, 8'h00, 8'h43, 8'h00,
        8'h20, 8'h00, 8'h41, 8'h00, 8'h43, 8'h00, 8'h4D, 8'h00,
        8'h0A, 8'h03, 8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00, 8'h34, 8'h00
    };

    localparam logic [ROM_AW-1:0] ROM_BASE [8] = '{
        ROM_AW'(0), ROM_AW'(18), ROM_AW'(85), ROM_AW'(95),
        ROM_AW'(102), ROM_AW'(106), ROM_AW'(126), ROM_AW'(142)
    };

    localparam logic [6:0] ROM_LEN [8] = '{
        7'd18, 7'd67, 7'd10, 7'd7, 7'd4, 7'd20, 7'd16, 7'd10
    };

    function automatic logic [7:0] rom_byte(input logic [2:0] sel, input logic [6:0] off);
        logic [ROM_AW-1:0] addr;
        logic [7:0]        data;
        addr = ROM_BASE[sel] + ROM_AW'(off);
        data = 8'h00;
        if (off < ROM_LEN[sel]) begin
            data = DESC_ROM[addr];
        end
        return data;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/usbcdc_if.sv @@
// usbcdc_req_if and usbcdc_rsp_if: valid/ready channels of the ep0 responder
// no dependencies
`default_nettype none

interface usbcdc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;

    modport source (
        output valid, kind, request_type, request_code, request_value, request_length,
        input  ready
    );
    modport sink (
        input  valid, kind, request_type, request_code, request_value, request_length,
        output ready
    );
endinterface

interface usbcdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       packet_end;
    logic       final_packet;
    logic [6:0] device_address;
    logic       configured;
    logic       dtr_on;
    logic       last;

    modport source (
        output valid, action, data_byte, packet_end, final_packet, device_address,
               configured, dtr_on, last,
        input  ready
    );
    modport sink (
        input  valid, action, data_byte, packet_end, final_packet, device_address,
               configured, dtr_on, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/usbcdc_ctrl.sv @@
// usbcdc_ctrl: sequencer of the ep0 responder (accept, chunk setup, emit)
// depends on usbcdc_pkg
`default_nettype none

module usbcdc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  usbcdc_pkg::t_dp_status i_status,
    output logic                   o_in_ready,
    output usbcdc_pkg::t_ctrl_cmd  o_cmd
);
    import usbcdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_status.next_step)
                        NEXT_SINGLE: n_state = ST_SINGLE;
                        NEXT_CHUNK:  n_state = ST_START;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                o_cmd.chunk_setup = 1'b1;
                n_state = i_status.chunk_empty ? ST_SINGLE : ST_STREAM;
            end
            ST_SINGLE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_STREAM: begin
                if (i_status.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_status.chunk_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/usbcdc_dp.sv @@
// usbcdc_dp: request decode, endpoint state, descriptor rom read and output register
// depends on usbcdc_pkg
`default_nettype none

module usbcdc_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  usbcdc_pkg::t_ctrl_cmd  i_cmd,
    input  usbcdc_pkg::t_req       i_req,
    input  logic                   i_rsp_ready,
    output usbcdc_pkg::t_dp_status o_status,
    output logic                   o_rsp_valid,
    output usbcdc_pkg::t_rsp       o_rsp
);
    import usbcdc_pkg::*;

    logic [2:0] r_sel,        n_sel;
    logic [6:0] r_offset,     n_offset;
    logic [6:0] r_remaining,  n_remaining;
    logic [6:0] r_pend_addr,  n_pend_addr;
    logic       r_addr_pending, n_addr_pending;
    logic       r_configured, n_configured;
    logic       r_dtr,        n_dtr;
    t_action    r_act,        n_act;
    logic [6:0] r_act_addr,   n_act_addr;
    logic       r_act_end,    n_act_end;
    logic [6:0] r_chunk_left, n_chunk_left;
    logic       r_fin,        n_fin;
    logic       r_out_valid,  n_out_valid;
    t_rsp       r_out,        n_out;

    logic [1:0] group;
    logic [7:0] desc_type;
    logic [7:0] desc_idx;
    logic       start_ok;
    logic [2:0] start_sel;
    logic [6:0] start_len;
    t_action    single_act;
    t_next      next_step;
    logic       byte_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel          <= '0;
            r_offset       <= '0;
            r_remaining    <= '0;
            r_pend_addr    <= '0;
            r_addr_pending <= 1'b0;
            r_configured   <= 1'b0;
            r_dtr          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_sel          <= n_sel;
            r_offset       <= n_offset;
            r_remaining    <= n_remaining;
            r_pend_addr    <= n_pend_addr;
            r_addr_pending <= n_addr_pending;
            r_configured   <= n_configured;
            r_dtr          <= n_dtr;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_act_addr   <= n_act_addr;
        r_act_end    <= n_act_end;
        r_chunk_left <= n_chunk_left;
        r_fin        <= n_fin;
        r_out        <= n_out;
    end

    // request decode
    always_comb begin
        group      = i_req.request_type[6:5];
        desc_type  = i_req.request_value[15:8];
        desc_idx   = i_req.request_value[7:0];
        start_ok   = 1'b0;
        start_sel  = SRC_DEVICE;
        single_act = ACT_STALL;
        if (group == GROUP_STANDARD && i_req.request_code == REQ_GET_DESCRIPTOR) begin
            case (desc_type)
                DESC_DEVICE: begin
                    start_ok  = 1'b1;
                    start_sel = SRC_DEVICE;
                end
                DESC_CONFIG: begin
                    start_ok  = 1'b1;
                    start_sel = SRC_CONFIG;
                end
                DESC_QUALIFIER: begin
                    start_ok  = 1'b1;
                    start_sel = SRC_QUALIFIER;
                end
                DESC_STRING: begin
                    if (desc_idx < 8'(STRING_LIMIT)) begin
                        start_ok  = 1'b1;
                        start_sel = SRC_STRING0 + desc_idx[2:0];
                    end
                end
                default: start_ok = 1'b0;
            endcase
        end else if (group == GROUP_STANDARD && i_req.request_code == REQ_SET_ADDRESS) begin
            single_act = ACT_ACK;
        end else if (group == GROUP_STANDARD
                     && i_req.request_code == REQ_SET_CONFIGURATION) begin
            single_act = ACT_ACK;
        end else if (group == GROUP_CLASS && i_req.request_code == REQ_GET_LINE_CODING) begin
            start_ok  = 1'b1;
            start_sel = SRC_LINE_CODING;
        end else if (group == GROUP_CLASS
                     && (i_req.request_code == REQ_SET_LINE_CODING
                         || i_req.request_code == REQ_SET_CONTROL_LINE_STATE)) begin
            single_act = ACT_ACK;
        end
        start_len = ({9'd0, ROM_LEN[start_sel]} > i_req.request_length)
                    ? i_req.request_length[6:0] : ROM_LEN[start_sel];
    end

    always_comb begin
        next_step = NEXT_NONE;
        case (i_req.kind)
            KIND_BUS_RESET: next_step = NEXT_SINGLE;
            KIND_SETUP:     next_step = start_ok ? NEXT_CHUNK : NEXT_SINGLE;
            KIND_IN_DONE: begin
                if (r_remaining != 7'd0) begin
                    next_step = NEXT_CHUNK;
                end else if (r_addr_pending) begin
                    next_step = NEXT_SINGLE;
                end
            end
            default: next_step = NEXT_NONE;
        endcase
    end

    // state update
    always_comb begin
        n_sel          = r_sel;
        n_offset       = r_offset;
        n_remaining    = r_remaining;
        n_pend_addr    = r_pend_addr;
        n_addr_pending = r_addr_pending;
        n_configured   = r_configured;
        n_dtr          = r_dtr;
        n_act          = r_act;
        n_act_addr     = r_act_addr;
        n_act_end      = r_act_end;
        n_chunk_left   = r_chunk_left;
        n_fin          = r_fin;
        if (i_cmd.accept) begin
            case (i_req.kind)
                KIND_BUS_RESET: begin
                    n_pend_addr    = '0;
                    n_addr_pending = 1'b0;
                    n_configured   = 1'b0;
                    n_act          = ACT_ADDRESS;
                    n_act_addr     = '0;
                    n_act_end      = 1'b0;
                end
                KIND_SETUP: begin
                    n_remaining = '0;
                    n_offset    = '0;
                    n_act       = single_act;
                    n_act_addr  = '0;
                    n_act_end   = 1'b0;
                    if (start_ok) begin
                        n_sel       = start_sel;
                        n_remaining = start_len;
                    end else if (single_act == ACT_ACK) begin
                        if (group == GROUP_STANDARD
                            && i_req.request_code == REQ_SET_ADDRESS) begin
                            n_pend_addr    = i_req.request_value[6:0];
                            n_addr_pending = 1'b1;
                        end else if (group == GROUP_STANDARD) begin
                            n_configured = 1'b1;
                        end else begin
                            n_dtr = i_req.request_value[0];
                        end
                    end
                end
                KIND_IN_DONE: begin
                    if (r_remaining == 7'd0 && r_addr_pending) begin
                        n_act          = ACT_ADDRESS;
                        n_act_addr     = r_pend_addr;
                        n_act_end      = 1'b0;
                        n_addr_pending = 1'b0;
                    end
                end
                default: n_act = r_act;
            endcase
        end
        if (i_cmd.chunk_setup) begin
            if (r_remaining == 7'd0) begin
                n_act      = ACT_ZLP;
                n_act_addr = '0;
                n_act_end  = 1'b1;
            end else begin
                n_chunk_left = (r_remaining > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : r_remaining;
                n_fin        = (r_remaining <= 7'(MAX_PACKET));
            end
        end
        if (i_cmd.emit_byte) begin
            n_offset     = r_offset + 7'd1;
            n_remaining  = r_remaining - 7'd1;
            n_chunk_left = r_chunk_left - 7'd1;
        end
    end

    // output register
    always_comb begin
        byte_end    = (r_chunk_left == 7'd1);
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_cmd.emit_single) begin
            n_out_valid          = 1'b1;
            n_out.action         = r_act;
            n_out.data_byte      = 8'h00;
            n_out.packet_end     = r_act_end;
            n_out.final_packet   = r_act_end;
            n_out.device_address = r_act_addr;
            n_out.configured     = r_configured;
            n_out.dtr_on         = r_dtr;
            n_out.last           = 1'b1;
        end else if (i_cmd.emit_byte) begin
            n_out_valid          = 1'b1;
            n_out.action         = ACT_DATA;
            n_out.data_byte      = rom_byte(r_sel, r_offset);
            n_out.packet_end     = byte_end;
            n_out.final_packet   = byte_end & r_fin;
            n_out.device_address = '0;
            n_out.configured     = r_configured;
            n_out.dtr_on         = r_dtr;
            n_out.last           = byte_end;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_status.next_step   = next_step;
    assign o_status.chunk_empty = (r_remaining == 7'd0);
    assign o_status.chunk_last  = (r_chunk_left == 7'd1);
    assign o_status.out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid          = r_out_valid;
    assign o_rsp                = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/usb_cdc_control_endpoint_responder.sv @@
// usb_cdc_control_endpoint_responder: ep0 responder top level for a cdc acm function
// depends on usbcdc_pkg, usbcdc_if, usbcdc_ctrl, usbcdc_dp
//
//  channel  dir  contents
//  i_req    in   event kind, bmRequestType, bRequest, wValue, wLength
//  o_rsp    out  action, data byte, packet end/final, address, configured, dtr, last
//
// each event is taken in an accept step, then a chunk setup step follows when data or a
// zero-length packet goes out, then one result byte per cycle (up to 64 per packet) is read
// from the descriptor rom while o_rsp is not stalled; ack, stall, address and zlp results
// are emitted from ST_SINGLE; reset is synchronous and clears the endpoint state and the
// output valid flag; a stalled o_rsp holds the rom stream; the next event is taken while
// the last result still waits in the output register
`default_nettype none

module usb_cdc_control_endpoint_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    usbcdc_req_if.sink          i_req,
    usbcdc_rsp_if.source        o_rsp
);
    import usbcdc_pkg::*;

    t_req       req;
    t_rsp       rsp;
    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       in_ready;
    logic       rsp_valid;

    assign req.kind           = i_req.kind;
    assign req.request_type   = i_req.request_type;
    assign req.request_code   = i_req.request_code;
    assign req.request_value  = i_req.request_value;
    assign req.request_length = i_req.request_length;

    usbcdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    usbcdc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (req),
        .i_rsp_ready (o_rsp.ready),
        .o_status    (status),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = rsp_valid;
    assign o_rsp.action         = rsp.action;
    assign o_rsp.data_byte      = rsp.data_byte;
    assign o_rsp.packet_end     = rsp.packet_end;
    assign o_rsp.final_packet   = rsp.final_packet;
    assign o_rsp.device_address = rsp.device_address;
    assign o_rsp.configured     = rsp.configured;
    assign o_rsp.dtr_on         = rsp.dtr_on;
    assign o_rsp.last           = rsp.last;

    a_final_closes_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.final_packet |-> o_rsp.packet_end)
        else $error("final packet flag without packet end");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.action != ACT_DATA |-> o_rsp.last)
        else $error("non-data result not marked last");

    a_mid_packet_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.action == ACT_DATA && !o_rsp.packet_end |-> !o_rsp.last)
        else $error("last marked inside an in packet");

    a_no_accept_mid_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_byte && !status.chunk_last |=> !i_req.ready)
        else $error("event taken while a packet is still streaming");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for the usb cdc ep0 responder
// drives setup, bus reset and in-done events and checks every response byte in order
// depends on usbcdc_pkg, usbcdc_if and usb_cdc_control_endpoint_responder
`timescale 1ns / 100ps

module tb_top;
    import usbcdc_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [7:0] RT_STD_OUT   = 8'h00;
    localparam logic [7:0] RT_STD_IN    = 8'h80;
    localparam logic [7:0] RT_CLASS_OUT = 8'h21;
    localparam logic [7:0] RT_CLASS_IN  = 8'hA1;
    localparam logic [7:0] RT_VENDOR    = 8'h40;
    localparam logic [7:0] RT_RESERVED  = 8'h60;
    localparam logic [7:0] REQ_UNKNOWN  = 8'hFF;
    localparam logic [7:0] DESC_UNKNOWN = 8'hFF;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 600000;

    class ep0_scoreboard;
        t_rsp       expected_q[$];
        t_rsp       step_q[$];
        int         errors;
        logic [7:0] desc_tbl[8][$];
        logic [2:0] src_sel;
        logic [6:0] rd_off;
        logic [6:0] remaining;
        logic [6:0] pend_addr;
        logic       addr_pend;
        logic       cfg_flag;
        logic       dtr_flag;

        function new();
            errors    = 0;
            src_sel   = '0;
            rd_off    = '0;
            remaining = '0;
            pend_addr = '0;
            addr_pend = 1'b0;
            cfg_flag  = 1'b0;
            dtr_flag  = 1'b0;
            desc_tbl[SRC_DEVICE] = '{8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h00,
                8'(MAX_PACKET), 8'h1C, 8'h1C, 8'h10, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02,
                8'h03, 8'h01};
            desc_tbl[SRC_CONFIG] = '{
                8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'hC0, 8'h32,
                8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
                8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
                8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
                8'h04, 8'h24, 8'h02, 8'h02,
                8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
                8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hFF,
                8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
                8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00,
                8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00};
            desc_tbl[SRC_QUALIFIER] = '{8'h0A, 8'h06, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00,
                8'(MAX_PACKET), 8'h01, 8'h00};
            desc_tbl[SRC_LINE_CODING] = '{8'h00, 8'hC2, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08};
            desc_tbl[SRC_STRING0] = '{8'h04, 8'h03, 8'h09, 8'h04};
            desc_tbl[SRC_STRING0 + 3'd1] = '{8'h14, 8'h03, 8'h46, 8'h00, 8'h72, 8'h00,
                8'h65, 8'h00, 8'h65, 8'h00, 8'h74, 8'h00, 8'h72, 8'h00, 8'h69, 8'h00,
                8'h62, 8'h00, 8'h65, 8'h00};
            desc_tbl[SRC_STRING0 + 3'd2] = '{8'h10, 8'h03, 8'h43, 8'h00, 8'h44, 8'h00,
                8'h43, 8'h00, 8'h20, 8'h00, 8'h41, 8'h00, 8'h43, 8'h00, 8'h4D, 8'h00};
            desc_tbl[SRC_STRING0 + 3'd3] = '{8'h0A, 8'h03, 8'h31, 8'h00, 8'h32, 8'h00,
                8'h33, 8'h00, 8'h34, 8'h00};
        endfunction

        function void push_rsp(t_action act, logic [7:0] data, logic pend, logic fin,
                               logic [6:0] addr);
            t_rsp r;
            r                = '0;
            r.action         = act;
            r.data_byte      = data;
            r.packet_end     = pend;
            r.final_packet   = fin;
            r.device_address = addr;
            step_q.push_back(r);
        endfunction

        // next in packet of the current data stage, or a zero-length packet
        function void send_packet();
            int   cnt;
            int   off;
            int   i;
            logic fin;
            logic [7:0] data;
            cnt = (int'(remaining) > MAX_PACKET) ? MAX_PACKET : int'(remaining);
            if (cnt == 0) begin
                push_rsp(ACT_ZLP, 8'h00, 1'b1, 1'b1, 7'd0);
                return;
            end
            fin = (int'(remaining) == cnt);
            for (i = 0; i < cnt; i++) begin
                off  = int'(rd_off) + i;
                data = (off < desc_tbl[src_sel].size()) ? desc_tbl[src_sel][off] : 8'h00;
                push_rsp(ACT_DATA, data, i == cnt - 1, (i == cnt - 1) && fin, 7'd0);
            end
            rd_off    = rd_off + 7'(cnt);
            remaining = remaining - 7'(cnt);
        endfunction

        function void begin_data(logic [2:0] sel, logic [15:0] wlen);
            int len;
            len = desc_tbl[sel].size();
            if (len > int'(wlen)) len = int'(wlen);
            src_sel   = sel;
            rd_off    = '0;
            remaining = 7'(len);
            send_packet();
        endfunction

        function void note_request(t_req req);
            logic [1:0] group;
            logic [7:0] dtype;
            logic [7:0] idx;
            step_q.delete();
            group = req.request_type[6:5];
            dtype = req.request_value[15:8];
            idx   = req.request_value[7:0];
            case (req.kind)
                KIND_BUS_RESET: begin
                    pend_addr = '0;
                    addr_pend = 1'b0;
                    cfg_flag  = 1'b0;
                    push_rsp(ACT_ADDRESS, 8'h00, 1'b0, 1'b0, 7'd0);
                end
                KIND_SETUP: begin
                    remaining = '0;
                    rd_off    = '0;
                    if (group == GROUP_STANDARD && req.request_code == REQ_GET_DESCRIPTOR) begin
                        if (dtype == DESC_DEVICE) begin
                            begin_data(SRC_DEVICE, req.request_length);
                        end else if (dtype == DESC_CONFIG) begin
                            begin_data(SRC_CONFIG, req.request_length);
                        end else if (dtype == DESC_QUALIFIER) begin
                            begin_data(SRC_QUALIFIER, req.request_length);
                        end else if (dtype == DESC_STRING && idx < STRING_COUNT && idx < 4) begin
                            begin_data(SRC_STRING0 + idx[2:0], req.request_length);
                        end else begin
                            push_rsp(ACT_STALL, 8'h00, 1'b0, 1'b0, 7'd0);
                        end
                    end else if (group == GROUP_STANDARD && req.request_code == REQ_SET_ADDRESS) begin
                        pend_addr = req.request_value[6:0];
                        addr_pend = 1'b1;
                        push_rsp(ACT_ACK, 8'h00, 1'b0, 1'b0, 7'd0);
                    end else if (group == GROUP_STANDARD &&
                                 req.request_code == REQ_SET_CONFIGURATION) begin
                        cfg_flag = 1'b1;
                        push_rsp(ACT_ACK, 8'h00, 1'b0, 1'b0, 7'd0);
                    end else if (group == GROUP_CLASS && req.request_code == REQ_GET_LINE_CODING) begin
                        begin_data(SRC_LINE_CODING, req.request_length);
                    end else if (group == GROUP_CLASS &&
                                 (req.request_code == REQ_SET_LINE_CODING ||
                                  req.request_code == REQ_SET_CONTROL_LINE_STATE)) begin
                        dtr_flag = req.request_value[0];
                        push_rsp(ACT_ACK, 8'h00, 1'b0, 1'b0, 7'd0);
                    end else begin
                        push_rsp(ACT_STALL, 8'h00, 1'b0, 1'b0, 7'd0);
                    end
                end
                KIND_IN_DONE: begin
                    if (remaining != 0) begin
                        send_packet();
                    end else if (addr_pend) begin
                        push_rsp(ACT_ADDRESS, 8'h00, 1'b0, 1'b0, pend_addr);
                        addr_pend = 1'b0;
                    end
                end
                default: ;
            endcase
            foreach (step_q[k]) begin
                step_q[k].configured = cfg_flag;
                step_q[k].dtr_on     = dtr_flag;
                step_q[k].last       = (k == step_q.size() - 1);
                expected_q.push_back(step_q[k]);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task cmp_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report("response with no transaction pending");
                return;
            end
            want = expected_q.pop_front();
            cmp_field("action", 8'(got.action), 8'(want.action));
            cmp_field("data_byte", got.data_byte, want.data_byte);
            cmp_field("packet_end", 8'(got.packet_end), 8'(want.packet_end));
            cmp_field("final_packet", 8'(got.final_packet), 8'(want.final_packet));
            cmp_field("device_address", 8'(got.device_address), 8'(want.device_address));
            cmp_field("configured", 8'(got.configured), 8'(want.configured));
            cmp_field("dtr_on", 8'(got.dtr_on), 8'(want.dtr_on));
            cmp_field("last", 8'(got.last), 8'(want.last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   idle_left = 0;
    bit   sender_idle = 1'b0;
    bit   recv_stall = 1'b0;
    bit   hold_off_req = 1'b0;

    ep0_scoreboard sb;

    usbcdc_req_if req_ch();
    usbcdc_rsp_if rsp_ch();

    usb_cdc_control_endpoint_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] kind, logic [7:0] rtype, logic [7:0] code,
                             logic [15:0] value, logic [15:0] wlen);
        int   gap;
        t_req r;
        if (idle_left == 0) begin
            sender_idle = !sender_idle;
            idle_left   = $urandom_range(10, 40);
        end
        idle_left--;
        gap = sender_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.kind           = kind;
        r.request_type   = rtype;
        r.request_code   = code;
        r.request_value  = value;
        r.request_length = wlen;
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= kind;
        req_ch.request_type   <= rtype;
        req_ch.request_code   <= code;
        req_ch.request_value  <= value;
        req_ch.request_length <= wlen;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(r);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    function automatic logic [15:0] rand_len();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 8));
            2:       return 16'($urandom_range(9, 80));
            3:       return 16'hFFFF;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(60, 70));
        endcase
    endfunction

    function automatic logic [7:0] std_rt();
        return {1'($urandom), GROUP_STANDARD, 5'($urandom)};
    endfunction

    function automatic logic [7:0] cls_rt();
        return {1'($urandom), GROUP_CLASS, 5'($urandom)};
    endfunction

    function automatic logic [15:0] rand_desc_value();
        case ($urandom_range(0, 9))
            0, 1:    return {DESC_DEVICE, 8'($urandom)};
            2, 3, 4: return {DESC_CONFIG, 8'($urandom)};
            5:       return {DESC_QUALIFIER, 8'($urandom)};
            6, 7:    return {DESC_STRING, 8'($urandom_range(0, 5))};
            8:       return {DESC_STRING, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int   gap;
        int   stall_left;
        t_rsp got;
        rsp_ch.ready <= 1'b0;
        stall_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_left == 0) begin
                recv_stall = !recv_stall;
                stall_left = $urandom_range(20, 80);
            end
            stall_left--;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = recv_stall ? $urandom_range(0, 4) : 0;
            end
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            got.action         = t_action'(rsp_ch.action);
            got.data_byte      = rsp_ch.data_byte;
            got.packet_end     = rsp_ch.packet_end;
            got.final_packet   = rsp_ch.final_packet;
            got.device_address = rsp_ch.device_address;
            got.configured     = rsp_ch.configured;
            got.dtr_on         = rsp_ch.dtr_on;
            got.last           = rsp_ch.last;
            sb.check_result(got);
        end
    end

    initial begin
        int start_count;
        int n_done;
        bit hold_done;
        bit pause_done;
        sb = new();
        hold_done  = 1'b0;
        pause_done = 1'b0;
        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.kind           <= KIND_BUS_RESET;
        req_ch.request_type   <= '0;
        req_ch.request_code   <= '0;
        req_ch.request_value  <= '0;
        req_ch.request_length <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_item(KIND_BUS_RESET, RT_STD_OUT, 8'h00, 16'h0000, 16'h0000);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'd64);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF);
        send_item(KIND_IN_DONE, RT_STD_OUT, 8'h00, 16'h0000, 16'h0000);
        send_item(KIND_IN_DONE, RT_STD_OUT, 8'h00, 16'h0000, 16'h0000);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_QUALIFIER, 8'h00}, 16'd0);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd0}, 16'd255);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd1}, 16'd2);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd2}, 16'hFFFF);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd3}, 16'd10);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd4}, 16'd64);
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_UNKNOWN, 8'hFF}, 16'd64);
        send_item(KIND_SETUP, RT_CLASS_IN, REQ_GET_LINE_CODING, 16'h0000, 16'hFFFF);
        send_item(KIND_SETUP, RT_CLASS_IN, REQ_GET_LINE_CODING, 16'h0000, 16'd3);
        send_item(KIND_SETUP, RT_CLASS_OUT, REQ_SET_LINE_CODING, 16'h0001, 16'd7);
        send_item(KIND_SETUP, RT_CLASS_OUT, REQ_SET_CONTROL_LINE_STATE, 16'hFFFE, 16'd0);
        send_item(KIND_SETUP, RT_CLASS_OUT, REQ_SET_CONTROL_LINE_STATE, 16'hFFFF, 16'd0);
        send_item(KIND_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'd0);
        send_item(KIND_IN_DONE, RT_STD_OUT, 8'h00, 16'h0000, 16'h0000);
        send_item(KIND_SETUP, RT_STD_OUT, REQ_SET_CONFIGURATION, 16'h0001, 16'd0);
        send_item(KIND_SETUP, RT_VENDOR, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'd18);
        send_item(KIND_SETUP, RT_RESERVED, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'd18);
        send_item(KIND_SETUP, RT_CLASS_OUT, REQ_UNKNOWN, 16'h0000, 16'd0);
        send_item(KIND_SETUP, RT_STD_OUT, REQ_UNKNOWN, 16'h0000, 16'd0);
        // new setup aborts a data stage in progress
        send_item(KIND_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF);
        send_item(KIND_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'h0005, 16'd0);
        send_item(KIND_IN_DONE, RT_STD_OUT, 8'h00, 16'h0000, 16'h0000);
        // bus reset drops a pending address
        send_item(KIND_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'h0009, 16'd0);
        send_item(KIND_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // random
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if (!hold_done && items_sent - start_count >= 100) begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                repeat (6) begin
                    send_item(KIND_SETUP, std_rt(), REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00},
                              16'hFFFF);
                    send_item(KIND_IN_DONE, 8'($urandom), 8'($urandom), 16'($urandom),
                              16'($urandom));
                end
            end
            if (!pause_done && items_sent - start_count >= 200) begin
                pause_done = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 99)) inside
                [0:34]: begin
                    send_item(KIND_SETUP, std_rt(), REQ_GET_DESCRIPTOR, rand_desc_value(),
                              rand_len());
                    n_done = $urandom_range(0, 2);
                    repeat (n_done) send_item(KIND_IN_DONE, 8'($urandom), 8'($urandom),
                                              16'($urandom), 16'($urandom));
                end
                [35:44]: begin
                    send_item(KIND_SETUP, cls_rt(), REQ_GET_LINE_CODING, 16'($urandom),
                              rand_len());
                    send_item(KIND_IN_DONE, 8'($urandom), 8'($urandom), 16'($urandom),
                              16'($urandom));
                end
                [45:54]: begin
                    send_item(KIND_SETUP, std_rt(), REQ_SET_ADDRESS, 16'($urandom),
                              16'($urandom));
                    if ($urandom_range(0, 3) != 0)
                        send_item(KIND_IN_DONE, 8'($urandom), 8'($urandom), 16'($urandom),
                                  16'($urandom));
                end
                [55:62]: send_item(KIND_SETUP, std_rt(), REQ_SET_CONFIGURATION,
                                   16'($urandom), 16'($urandom));
                [63:72]: send_item(KIND_SETUP, cls_rt(),
                                   $urandom_range(0, 1) ? REQ_SET_LINE_CODING
                                                        : REQ_SET_CONTROL_LINE_STATE,
                                   16'($urandom), 16'($urandom));
                [73:80]: send_item(KIND_BUS_RESET, 8'($urandom), 8'($urandom),
                                   16'($urandom), 16'($urandom));
                [81:89]: send_item(KIND_IN_DONE, 8'($urandom), 8'($urandom),
                                   16'($urandom), 16'($urandom));
                default: send_item(2'($urandom), 8'($urandom), 8'($urandom),
                                   16'($urandom), 16'($urandom));
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
